[hw/rtl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg: shared types and codes for the sequence pattern matcher
// Operation codes, the cell command bundle and the packed result word.
// ----------------------------------------------------------------------------
package spm_pkg;

   localparam int VALUE_W = 32;
   localparam int ROW_W   = 8;
   localparam int RSP_W   = 16;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic               shift;
      logic               flush;
      logic [VALUE_W-1:0] value;
   } spm_cmd_type;

   // Result word, found in the lowest bit
   typedef struct packed {
      logic             pattern_truncated;
      logic [ROW_W-1:0] row_number;
      logic             found;
   } spm_rsp_type;

endpackage

[hw/rtl/spm_cell.sv]
// ----------------------------------------------------------------------------
// spm_cell: one compare cell of the matcher chain
// Holds one pattern element and the partial-match bit for its position.
// ----------------------------------------------------------------------------
module spm_cell
   import spm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  spm_cmd_type         cmd,
   input  logic                load,
   input  logic                prev_match,
   output logic                match,
   output logic                hit
);

   logic [VALUE_W-1:0] pat_ff;
   logic               match_ff;
   logic               match_in;

   assign hit   = prev_match && (pat_ff == cmd.value);
   assign match = match_ff;

   always_comb begin
      match_in = match_ff;
      if (cmd.flush) begin
         match_in = 1'b0;
      end else if (cmd.shift) begin
         match_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pat_ff <= cmd.value;
      end
   end

endmodule

[hw/rtl/sequence_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// sequence_pattern_matcher: exact substring search over streamed text rows
// A chain of compare cells tracks every pattern prefix ending at the current
// text element; one result beat leaves at the end of each row.
//
//   channel | direction | tdata                 | tuser     | tlast
//   req_    | in        | value[31:0]           | operation | row_end
//   rsp_    | out       | found, row_number,    | -         | -
//           |           | pattern_truncated     |           |
//
// One input beat per cycle while ready; all cells compare against the
// broadcast value in the same cycle. A row-end result goes to the output
// register, or to the skid register while the output is held. Input stalls
// only while the skid register is occupied. Reset empties the pattern and
// clears all counters and flags; the first beat is taken right after reset.
// ----------------------------------------------------------------------------
module sequence_pattern_matcher
   import spm_pkg::*;
#(
   parameter int PATTERN_MAX = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [31:0] value
   input  logic [1:0]        req_tuser,   // [1:0] operation
   input  logic              req_tlast,   // row_end
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // [0] found, [8:1] row_number,
                                          // [9] pattern_truncated, [15:10] 0
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int PAD_W = RSP_W - $bits(spm_rsp_type);

   logic [LEN_W-1:0] len_ff, len_in;
   logic             row_found_ff, row_found_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic             trunc_ff, trunc_in;
   logic             out_valid_ff, out_valid_in;
   spm_rsp_type      out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   spm_rsp_type      skid_data_ff, skid_data_in;

   logic             accept, is_clear, is_append, is_text;
   logic             len_zero, len_full, row_done, found_now, last_hit;
   spm_cmd_type      cmd;
   spm_rsp_type      result;
   logic [PATTERN_MAX-1:0] load, match, hit, sel;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_clear   = (req_tuser == OP_CLEAR);
   assign is_append  = (req_tuser == OP_APPEND);
   assign is_text    = (req_tuser == OP_TEXT);
   assign len_zero   = (len_ff == '0);
   assign len_full   = (len_ff == LEN_W'(PATTERN_MAX));
   assign row_done   = accept && is_text && req_tlast;

   assign cmd.value = req_tdata;
   assign cmd.shift = accept && is_text && !len_zero;
   assign cmd.flush = accept && (is_clear || is_append || (is_text && req_tlast));

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         load[k] = accept && is_append && (len_ff == LEN_W'(k));
         sel[k]  = (len_ff == LEN_W'(k + 1));
      end
   end

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      spm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .load       (load[g]),
         .prev_match ((g == 0) ? 1'b1 : match[(g == 0) ? 0 : g - 1]),
         .match      (match[g]),
         .hit        (hit[g])
      );
   end

   // Full-pattern hit comes from the cell at the last pattern position
   assign last_hit  = |(hit & sel);
   assign found_now = row_found_ff || last_hit;

   assign result.found             = found_now || len_zero;
   assign result.row_number        = row_cnt_ff;
   assign result.pattern_truncated = trunc_ff;

   always_comb begin
      len_in       = len_ff;
      row_found_in = row_found_ff;
      row_cnt_in   = row_cnt_ff;
      trunc_in     = trunc_ff;
      if (accept) begin
         case (req_tuser)
            OP_CLEAR: begin
               len_in       = '0;
               row_found_in = 1'b0;
               row_cnt_in   = '0;
               trunc_in     = 1'b0;
            end
            OP_APPEND: begin
               if (len_full) begin
                  trunc_in = 1'b1;
               end else begin
                  len_in = len_ff + LEN_W'(1);
               end
            end
            OP_TEXT: begin
               if (req_tlast) begin
                  row_found_in = 1'b0;
                  row_cnt_in   = row_cnt_ff + ROW_W'(1);
               end else begin
                  row_found_in = found_now;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Output register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = row_done;
            out_data_in  = result;
         end
      end else if (row_done) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         row_found_ff  <= 1'b0;
         row_cnt_ff    <= '0;
         trunc_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         len_ff        <= len_in;
         row_found_ff  <= row_found_in;
         row_cnt_ff    <= row_cnt_in;
         trunc_ff      <= trunc_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_data_ff};

endmodule

[hw/rtl/spm_chk.sv]
// ----------------------------------------------------------------------------
// spm_chk: port-level checks for the sequence pattern matcher
// Watches both streams and the row-end to result relation.
// ----------------------------------------------------------------------------
module spm_chk
   import spm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [31:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata
);

   logic req_beat, row_end_beat;

   assign req_beat     = req_tvalid && req_tready;
   assign row_end_beat = req_beat && (req_tuser == OP_TEXT) && req_tlast;

   // A held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // After a row end, a result beat is valid in the next cycle
   a_row_result: assert property (@(posedge clock) disable iff (reset)
      row_end_beat |=> rsp_tvalid)
      else $error("row end gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !row_end_beat |=> !rsp_tvalid)
      else $error("result beat without a row end");

   // Input stalls only behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

endmodule

bind sequence_pattern_matcher spm_chk u_spm_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[sim/tb_sequence_pattern_matcher.sv]
// ----------------------------------------------------------------------------
// tb_sequence_pattern_matcher: self-checking bench for the pattern matcher
// Sends clear, append and text beats through the request stream and checks
// each row outcome against a behavioural copy of the prefix-match chain.
// It starts with a table of directed beats, then runs random phases built
// from small alphabets so that matches are common, including a long run of
// short rows that wraps the row counter. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb_sequence_pattern_matcher;
   import spm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PATTERN_MAX = 16;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int BEAT_TARGET = 900;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
      logic        row_end;
      logic        typed;
      spm_rsp_type rsp;
   } beat_row_type;

   localparam spm_rsp_type NO_RSP = '0;
   localparam int DIRECTED_ROWS = 21;
   localparam beat_row_type DIRECTED[DIRECTED_ROWS] = '{
      '{OP_TEXT,    32'h0000_0000, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1}},
      '{OP_IGNORED, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h8000_0000, 1'b1, 1'b1, '{1'b0, 8'd1, 1'b1}},
      '{OP_CLEAR,   32'h0000_0000, 1'b0, 1'b0, NO_RSP},
      '{OP_APPEND,  32'h7FFF_FFFF, 1'b0, 1'b0, NO_RSP},
      '{OP_APPEND,  32'h8000_0000, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h7FFF_FFFF, 1'b0, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h8000_0000, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h7FFF_FFFF, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h7FFF_FFFF, 1'b0, 1'b0, NO_RSP},
      '{OP_APPEND,  32'h0000_0000, 1'b0, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h8000_0000, 1'b0, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h0000_0000, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h7FFF_FFFF, 1'b0, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h8000_0000, 1'b0, 1'b0, NO_RSP},
      '{OP_TEXT,    32'h0000_0000, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'hFFFF_FFFF, 1'b0, 1'b0, NO_RSP},
      '{OP_CLEAR,   32'hFFFF_FFFF, 1'b1, 1'b0, NO_RSP},
      '{OP_TEXT,    32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 8'd0, 1'b1}},
      '{OP_TEXT,    32'h5555_5555, 1'b0, 1'b0, NO_RSP},
      '{OP_TEXT,    32'hAAAA_AAAA, 1'b1, 1'b1, '{1'b0, 8'd1, 1'b1}}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata = '0;   // [31:0] value
   logic [1:0]       req_tuser = '0;   // [1:0] operation
   logic             req_tlast = 1'b0; // row_end
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // [0] found, [8:1] row_number,
                                       // [9] pattern_truncated

   // behavioural copy of the matcher
   logic [31:0]            pat_mem[PATTERN_MAX];
   int                     pat_len;
   logic [PATTERN_MAX-1:0] prefix_hits;
   logic                   row_hit;
   logic [7:0]             row_idx;
   logic                   trunc_seen;

   spm_rsp_type row_outcomes[$];
   int          error_count;
   int          beats_counted;
   bit          steady_phase;
   int          stall_left;

   sequence_pattern_matcher #(.PATTERN_MAX(PATTERN_MAX)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Update the match state for one accepted beat; returns 1 with the outcome
   // when the beat closes a row.
   function automatic bit advance_search(input logic [1:0] op, input logic [31:0] value,
                                         input logic row_end, output spm_rsp_type outcome);
      outcome = '0;
      case (op)
         OP_CLEAR: begin
            pat_len     = 0;
            prefix_hits = '0;
            row_hit     = 1'b0;
            row_idx     = '0;
            trunc_seen  = 1'b0;
         end
         OP_APPEND: begin
            if (pat_len < PATTERN_MAX) begin
               pat_mem[pat_len] = value;
               pat_len++;
            end else begin
               trunc_seen = 1'b1;
            end
            prefix_hits = '0;
         end
         OP_TEXT: begin
            if (pat_len != 0) begin
               for (int k = pat_len - 1; k > 0; k--)
                  prefix_hits[k] = prefix_hits[k-1] && (pat_mem[k] == value);
               prefix_hits[0] = (pat_mem[0] == value);
               if (prefix_hits[pat_len-1]) row_hit = 1'b1;
            end
            if (row_end) begin
               outcome.found             = row_hit || (pat_len == 0);
               outcome.row_number        = row_idx;
               outcome.pattern_truncated = trunc_seen;
               row_idx     = row_idx + 8'd1;
               row_hit     = 1'b0;
               prefix_hits = '0;
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // mostly short, now and then long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Present one beat, hold it until taken, then book its expected outcome.
   task automatic push_beat(input logic [1:0] op, input logic [31:0] value,
                            input logic row_end, input bit use_typed = 1'b0,
                            input spm_rsp_type typed_rsp = '0);
      int          gap;
      spm_rsp_type outcome;
      gap = (!steady_phase && $urandom_range(0, 99) < 40) ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= op;
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      if (advance_search(op, value, row_end, outcome)) begin
         if (use_typed) outcome = typed_rsp;
         row_outcomes.push_back(outcome);
      end
      if (op != OP_IGNORED) beats_counted++;
   endtask

   // hold the request stream until every booked outcome has arrived
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (row_outcomes.size() != 0);
   endtask

   task automatic run_phase();
      logic [31:0] letters[4];
      logic [31:0] pattern[$];
      logic [31:0] row_data[$];
      int          n_letters;
      int          plen;
      int          eff;
      int          rl;
      int          pos;
      int          pick;
      steady_phase = ($urandom_range(0, 4) == 0);
      n_letters = $urandom_range(2, 4);
      foreach (letters[i]) letters[i] = $urandom();
      if ($urandom_range(0, 5) != 0)
         push_beat(OP_CLEAR, $urandom(), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 19);
      if (pick == 0) plen = 0;
      else if (pick == 1) plen = PATTERN_MAX;
      else if (pick == 2) plen = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
      else if (pick < 14) plen = $urandom_range(1, 4);
      else plen = $urandom_range(5, PATTERN_MAX - 1);
      for (int i = 0; i < plen; i++) begin
         pattern.push_back(letters[$urandom_range(0, n_letters - 1)]);
         push_beat(OP_APPEND, pattern[i], 1'($urandom_range(0, 1)));
      end
      eff = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
      repeat ($urandom_range(1, 8)) begin
         rl = $urandom_range(1, eff + 6);
         row_data.delete();
         repeat (rl)
            row_data.push_back(($urandom_range(0, 9) == 0) ? $urandom()
                               : letters[$urandom_range(0, n_letters - 1)]);
         // plant the pattern in about half the rows long enough to hold it
         if (eff > 0 && rl >= eff && $urandom_range(0, 1) == 1) begin
            pos = $urandom_range(0, rl - eff);
            for (int i = 0; i < eff; i++) row_data[pos + i] = pattern[i];
         end
         foreach (row_data[i]) begin
            if ($urandom_range(0, 39) == 0) begin
               pick = $urandom_range(0, 4);
               if (pick < 2)
                  push_beat(OP_IGNORED, $urandom(), 1'($urandom_range(0, 1)));
               else if (pick < 4)
                  push_beat(OP_APPEND, letters[0], 1'($urandom_range(0, 1)));
               else
                  push_beat(OP_CLEAR, $urandom(), 1'($urandom_range(0, 1)));
            end
            push_beat(OP_TEXT, row_data[i], i == row_data.size() - 1);
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (row_outcomes.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_tdata));
         end else begin
            spm_rsp_type want;
            spm_rsp_type got;
            want = row_outcomes.pop_front();
            got  = rsp_tdata[$bits(spm_rsp_type)-1:0];
            if (got.found !== want.found)
               report_mismatch($sformatf("row %0d found %b, want %b",
                                         want.row_number, got.found, want.found));
            if (got.row_number !== want.row_number)
               report_mismatch($sformatf("row_number %0d, want %0d",
                                         got.row_number, want.row_number));
            if (got.pattern_truncated !== want.pattern_truncated)
               report_mismatch($sformatf("row %0d pattern_truncated %b, want %b",
                                         want.row_number, got.pattern_truncated,
                                         want.pattern_truncated));
            if (rsp_tdata[RSP_W-1:$bits(spm_rsp_type)] !== '0)
               report_mismatch($sformatf("padding bits set in %h", rsp_tdata));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!steady_phase && $urandom_range(0, 99) < 25) begin
         stall_left = idle_length() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      logic [31:0] sym_a;
      logic [31:0] sym_b;
      bit          wrap_done;
      int          phase_idx;
      pat_len      = 0;
      prefix_hits  = '0;
      row_hit      = 1'b0;
      row_idx      = '0;
      trunc_seen   = 1'b0;
      error_count  = 0;
      beats_counted = 0;
      steady_phase = 1'b0;
      stall_left   = 0;
      wrap_done    = 1'b0;
      phase_idx    = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         push_beat(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].row_end,
                   DIRECTED[i].typed, DIRECTED[i].rsp);

      while (beats_counted < BEAT_TARGET) begin
         if (!wrap_done && beats_counted >= 300) begin
            // many short rows without a clear: run the row counter past 255
            wait_for_results();
            steady_phase = 1'b0;
            sym_a = $urandom();
            sym_b = $urandom();
            push_beat(OP_CLEAR, $urandom(), 1'b0);
            if ($urandom_range(0, 1) == 1) push_beat(OP_APPEND, sym_a, 1'b0);
            repeat (260) begin
               if ($urandom_range(0, 1) == 1)
                  push_beat(OP_TEXT, $urandom_range(0, 1) ? sym_a : sym_b, 1'b0);
               push_beat(OP_TEXT, $urandom_range(0, 1) ? sym_a : sym_b, 1'b1);
            end
            wrap_done = 1'b1;
         end else begin
            if (phase_idx % 4 == 0) wait_for_results();
            run_phase();
         end
         phase_idx++;
      end

      wait_for_results();
      steady_phase = 1'b0;
      repeat (8) @(posedge clock);
      if (error_count == 0 && row_outcomes.size() == 0) begin
         $display("** sequence_pattern_matcher: PASSED **");
      end else begin
         $display("** sequence_pattern_matcher: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** sequence_pattern_matcher: FAILED **");
      $finish;
   end

endmodule
